### src/channel_modulation_effects_assert.svh
// Assertion macros shared by the channel modulation effects block.
`ifndef CHANNEL_MODULATION_EFFECTS_ASSERT_SVH
`define CHANNEL_MODULATION_EFFECTS_ASSERT_SVH

// Check outside reset.
`define CME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every edge, reset included.
`define CME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### src/cme_pkg.sv
package cme_pkg;

  localparam int unsigned CME_VOICES = 8;

  localparam logic signed [16:0] CME_PORTA_SPAN = 17'sd12;
  localparam logic [6:0] CME_VOL_MAX = 7'd64;

  typedef enum logic {
    REQ_APPLY = 1'b0,
    REQ_TICK  = 1'b1
  } cme_req_type_e;

  typedef enum logic [3:0] {
    CMD_ARP       = 4'h0,
    CMD_PORTA_UP  = 4'h1,
    CMD_PORTA_DN  = 4'h2,
    CMD_VIBRATO   = 4'h4,
    CMD_VOL_SLIDE = 4'hA
  } cme_cmd_e;

  typedef struct packed {
    logic [3:0]  arp_first;
    logic [3:0]  arp_second;
    logic [1:0]  arp_position;
    logic        fx_enabled;
    logic [15:0] slide_target;
    logic [7:0]  slide_speed;
    logic [3:0]  wobble_speed;
    logic [3:0]  wobble_depth;
    logic [5:0]  wobble_position;
    logic [4:0]  fade_step;
    logic [6:0]  fade_level;
  } cme_entry_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  command;
    logic [7:0]  parameter_req;
    logic        voice_on;
    logic [15:0] voice_pitch;
    logic [15:0] voice_lfo_phase;
  } cme_req_t;

  typedef struct packed {
    logic [15:0] new_pitch;
    logic [15:0] new_lfo_phase;
  } cme_res_t;

  function automatic logic [7:0] cme_sine(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'd0;
      4'd1:    val = 8'd24;
      4'd2:    val = 8'd49;
      4'd3:    val = 8'd74;
      4'd4:    val = 8'd97;
      4'd5:    val = 8'd120;
      4'd6:    val = 8'd141;
      4'd7:    val = 8'd161;
      4'd8:    val = 8'd180;
      4'd9:    val = 8'd197;
      4'd10:   val = 8'd212;
      4'd11:   val = 8'd224;
      4'd12:   val = 8'd235;
      4'd13:   val = 8'd244;
      4'd14:   val = 8'd250;
      4'd15:   val = 8'd253;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  function automatic logic [15:0] cme_sat16(input logic signed [16:0] v);
    logic [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### src/cme_req_if.sv
interface cme_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  channel;
  logic [3:0]  command;
  logic [7:0]  parameter_req;
  logic        voice_on;
  logic signed [15:0] voice_pitch;
  logic [15:0] voice_lfo_phase;

  modport source (
    output valid, req_type, channel, command, parameter_req, voice_on, voice_pitch,
           voice_lfo_phase,
    input  ready
  );

  modport sink (
    input  valid, req_type, channel, command, parameter_req, voice_on, voice_pitch,
           voice_lfo_phase,
    output ready
  );
endinterface

### src/cme_rsp_if.sv
interface cme_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_channel;
  logic signed [15:0] new_pitch;
  logic [15:0] new_lfo_phase;
  logic [6:0]  volume_level;
  logic [1:0]  arp_step;
  logic        effect_on;

  modport source (
    output valid, out_channel, new_pitch, new_lfo_phase, volume_level, arp_step, effect_on,
    input  ready
  );

  modport sink (
    input  valid, out_channel, new_pitch, new_lfo_phase, volume_level, arp_step, effect_on,
    output ready
  );
endinterface

### src/channel_modulation_effects.sv
// Requests are taken only in the idle state: accepting one starts the effect memory read,
// and the execute state computes the result and writes back the modified entry, after
// which the block returns to idle; a new request is not taken before then.
// A result waiting at the output holds the write-back until it is taken.
// Reset: asynchronous, active low; clears per-voice valid bits so every entry
// reads as zero at once, with no clearing pass.
`include "channel_modulation_effects_assert.svh"

module channel_modulation_effects import cme_pkg::*; #(
  parameter int unsigned VOICES = CME_VOICES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cme_req_if.sink    req_i,
  cme_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e     state_q, state_d;
  cme_req_t   req_q;
  logic [AW-1:0] ch_q;
  logic [AW-1:0] ch_in;
  logic       accept;
  logic       fire;
  cme_entry_t rd_entry;
  cme_entry_t wr_entry;
  cme_res_t   res;

  logic       out_valid_q, out_valid_d;
  logic [2:0] out_channel_q;
  cme_res_t   out_res_q;
  logic [6:0] out_volume_q;
  logic [1:0] out_arp_q;
  logic       out_fx_q;

  assign ch_in  = (req_i.channel >= 8'(VOICES)) ? AW'(VOICES - 1) : req_i.channel[AW-1:0];
  assign req_i.ready = (state_q == S_IDLE);
  assign accept = req_i.valid && req_i.ready;
  assign fire   = (state_q == S_EXEC) && (!out_valid_q || rsp_o.ready);

  cme_fx_store #(
    .VOICES (VOICES),
    .AW     (AW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (ch_in),
    .rd_entry_o (rd_entry),
    .wr_en_i    (fire),
    .wr_addr_i  (ch_q),
    .wr_entry_i (wr_entry)
  );

  cme_fx_alu u_alu (
    .req_i   (req_q),
    .entry_i (rd_entry),
    .entry_o (wr_entry),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q                  <= ch_in;
      req_q.req_type        <= req_i.req_type;
      req_q.command         <= req_i.command;
      req_q.parameter_req   <= req_i.parameter_req;
      req_q.voice_on        <= req_i.voice_on;
      req_q.voice_pitch     <= req_i.voice_pitch;
      req_q.voice_lfo_phase <= req_i.voice_lfo_phase;
    end
    if (fire) begin
      out_channel_q <= 3'(ch_q);
      out_res_q     <= res;
      out_volume_q  <= wr_entry.fade_level;
      out_arp_q     <= wr_entry.arp_position;
      out_fx_q      <= wr_entry.fx_enabled;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.out_channel   = out_channel_q;
  assign rsp_o.new_pitch     = $signed(out_res_q.new_pitch);
  assign rsp_o.new_lfo_phase = out_res_q.new_lfo_phase;
  assign rsp_o.volume_level  = out_volume_q;
  assign rsp_o.arp_step      = out_arp_q;
  assign rsp_o.effect_on     = out_fx_q;

  `CME_ASSERT_ALWAYS(a_state_onehot, !rst_ni || $onehot(state_q), "state register not one-hot")
  `CME_ASSERT(a_accept_to_exec, accept |=> (state_q == S_EXEC), "accepted request not executed")
  `CME_ASSERT(a_no_rd_wr_overlap, !(accept && fire), "memory read overlaps write-back")
  `CME_ASSERT(a_rsp_from_exec, $rose(out_valid_q) |-> $past(state_q == S_EXEC), "result without execution")
  `CME_ASSERT(a_rsp_range, out_valid_q |-> ((out_volume_q <= CME_VOL_MAX) && (out_arp_q != 2'd3)), "result state out of range")

endmodule

### src/cme_fx_store.sv
module cme_fx_store import cme_pkg::*; #(
  parameter int unsigned VOICES = CME_VOICES,
  parameter int unsigned AW     = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output cme_entry_t    rd_entry_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  cme_entry_t    wr_entry_i
);

  cme_entry_t          mem_q [VOICES];
  cme_entry_t          rd_data_q;
  logic [VOICES-1:0]   valid_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

### src/cme_fx_alu.sv
module cme_fx_alu import cme_pkg::*; (
  input  cme_req_t   req_i,
  input  cme_entry_t entry_i,
  output cme_entry_t entry_o,
  output cme_res_t   res_o
);

  logic [3:0]         hi;
  logic [3:0]         lo;
  logic signed [15:0] pitch;
  logic signed [15:0] target;
  logic signed [16:0] porta_up;
  logic signed [16:0] porta_dn;
  logic [5:0]         wob_pos;
  logic [11:0]        wob_prod;
  logic signed [17:0] pitch_x;
  logic signed [17:0] target_x;
  logic signed [17:0] speed_x;
  logic signed [17:0] slide_up;
  logic signed [17:0] slide_dn;
  logic signed [8:0]  fade_sum;
  logic [6:0]         fade_new;
  logic [1:0]         arp_next;

  assign hi       = req_i.parameter_req[7:4];
  assign lo       = req_i.parameter_req[3:0];
  assign pitch    = $signed(req_i.voice_pitch);
  assign target   = $signed(entry_i.slide_target);
  assign porta_up = 17'(pitch) + CME_PORTA_SPAN;
  assign porta_dn = 17'(pitch) - CME_PORTA_SPAN;

  assign wob_pos  = entry_i.wobble_position + {2'b00, entry_i.wobble_speed};
  assign wob_prod = {4'd0, cme_sine(wob_pos[3:0])} * {8'd0, entry_i.wobble_depth};

  assign pitch_x  = 18'(pitch);
  assign target_x = 18'(target);
  assign speed_x  = $signed({10'd0, entry_i.slide_speed});
  assign slide_up = pitch_x + speed_x;
  assign slide_dn = pitch_x - speed_x;

  assign fade_sum = $signed({2'b00, entry_i.fade_level}) + 9'($signed(entry_i.fade_step));

  always_comb begin
    if (fade_sum < 9'sd0) begin
      fade_new = 7'd0;
    end else if (fade_sum > $signed({2'b00, CME_VOL_MAX})) begin
      fade_new = CME_VOL_MAX;
    end else begin
      fade_new = fade_sum[6:0];
    end
  end

  always_comb begin
    case (entry_i.arp_position)
      2'd0:    arp_next = 2'd1;
      2'd1:    arp_next = 2'd2;
      2'd2:    arp_next = 2'd0;
      default: arp_next = 2'd1;
    endcase
  end

  always_comb begin
    entry_o             = entry_i;
    res_o.new_pitch     = req_i.voice_pitch;
    res_o.new_lfo_phase = req_i.voice_lfo_phase;
    if (req_i.req_type == REQ_APPLY) begin
      case (cme_cmd_e'(req_i.command))
        CMD_ARP: begin
          entry_o.arp_first    = hi;
          entry_o.arp_second   = lo;
          entry_o.arp_position = 2'd0;
          entry_o.fx_enabled   = (req_i.parameter_req != 8'd0);
        end
        CMD_PORTA_UP: begin
          entry_o.slide_target = cme_sat16(porta_up);
          entry_o.slide_speed  = req_i.parameter_req;
          entry_o.fx_enabled   = 1'b1;
        end
        CMD_PORTA_DN: begin
          entry_o.slide_target = cme_sat16(porta_dn);
          entry_o.slide_speed  = req_i.parameter_req;
          entry_o.fx_enabled   = 1'b1;
        end
        CMD_VIBRATO: begin
          entry_o.wobble_speed = hi;
          entry_o.wobble_depth = lo;
          entry_o.fx_enabled   = (req_i.parameter_req != 8'd0);
        end
        CMD_VOL_SLIDE: begin
          entry_o.fade_step  = (hi != 4'd0) ? {1'b0, hi} : 5'(5'd0 - {1'b0, lo});
          entry_o.fx_enabled = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (entry_i.fx_enabled && req_i.voice_on) begin
      if (entry_i.wobble_depth != 4'd0) begin
        entry_o.wobble_position = wob_pos;
        res_o.new_lfo_phase     = req_i.voice_lfo_phase + {10'd0, wob_prod[11:6]};
      end
      if (entry_i.slide_speed != 8'd0) begin
        if (pitch < target) begin
          res_o.new_pitch = (slide_up > target_x) ? entry_i.slide_target : slide_up[15:0];
        end else if (pitch > target) begin
          res_o.new_pitch = (slide_dn < target_x) ? entry_i.slide_target : slide_dn[15:0];
        end
      end
      if (entry_i.fade_step != 5'd0) begin
        entry_o.fade_level = fade_new;
      end
      if ((entry_i.arp_first != 4'd0) || (entry_i.arp_second != 4'd0)) begin
        entry_o.arp_position = arp_next;
      end
    end
  end

endmodule

### tb/tb_top.sv
module tb_top;
  import cme_pkg::*;

  localparam int VOICES = CME_VOICES;
  localparam int RANDOM_ITEMS = 850;
  localparam int PLAN_ROWS = 26;
  localparam logic [3:0] CMD_UNUSED = 4'h3;

  localparam logic [7:0] SINE_LUT [16] = '{
    8'd0, 8'd24, 8'd49, 8'd74, 8'd97, 8'd120, 8'd141, 8'd161,
    8'd180, 8'd197, 8'd212, 8'd224, 8'd235, 8'd244, 8'd250, 8'd253
  };

  localparam cme_cmd_e KNOWN_CMDS [5] = '{
    CMD_ARP, CMD_PORTA_UP, CMD_PORTA_DN, CMD_VIBRATO, CMD_VOL_SLIDE
  };

  typedef struct packed {
    cme_req_type_e      kind;
    logic [7:0]         channel;
    logic [3:0]         command;
    logic [7:0]         param;
    logic               voice_on;
    logic signed [15:0] pitch;
    logic [15:0]        phase;
  } fx_req_t;

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [15:0] pitch;
    logic [15:0]        phase;
    logic [6:0]         vol;
    logic [1:0]         arp;
    logic               fx;
  } fx_res_t;

  typedef struct packed {
    fx_req_t rq;
    logic    fixed;
    fx_res_t rs;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{'{REQ_TICK, 8'd0, CMD_ARP, 8'h00, 1'b1, 16'sd100, 16'd500}, 1'b1,
      '{3'd0, 16'sd100, 16'd500, 7'd0, 2'd0, 1'b0}},
    '{'{REQ_APPLY, 8'd255, CMD_ARP, 8'h00, 1'b1, 16'h1234, 16'hABCD}, 1'b1,
      '{3'd7, 16'h1234, 16'hABCD, 7'd0, 2'd0, 1'b0}},
    '{'{REQ_APPLY, 8'd200, CMD_UNUSED, 8'hFF, 1'b0, 16'h8000, 16'hFFFF}, 1'b1,
      '{3'd7, 16'h8000, 16'hFFFF, 7'd0, 2'd0, 1'b0}},
    '{'{REQ_APPLY, 8'd1, CMD_ARP, 8'h37, 1'b1, 16'h0000, 16'h0000}, 1'b1,
      '{3'd1, 16'h0000, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd1, CMD_ARP, 8'h00, 1'b1, 16'h0040, 16'h0010}, 1'b1,
      '{3'd1, 16'h0040, 16'h0010, 7'd0, 2'd1, 1'b1}},
    '{'{REQ_TICK, 8'd1, CMD_ARP, 8'h00, 1'b0, 16'h0040, 16'h0010}, 1'b1,
      '{3'd1, 16'h0040, 16'h0010, 7'd0, 2'd1, 1'b1}},
    '{'{REQ_TICK, 8'd1, CMD_ARP, 8'h00, 1'b1, 16'h0040, 16'h0010}, 1'b1,
      '{3'd1, 16'h0040, 16'h0010, 7'd0, 2'd2, 1'b1}},
    '{'{REQ_TICK, 8'd1, CMD_ARP, 8'h00, 1'b1, 16'h0040, 16'h0010}, 1'b1,
      '{3'd1, 16'h0040, 16'h0010, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_APPLY, 8'd2, CMD_PORTA_UP, 8'hFF, 1'b1, 16'h7FF8, 16'h0000}, 1'b1,
      '{3'd2, 16'h7FF8, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd2, CMD_ARP, 8'h00, 1'b1, 16'h7FF8, 16'h0100}, 1'b1,
      '{3'd2, 16'h7FFF, 16'h0100, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_APPLY, 8'd3, CMD_PORTA_DN, 8'h05, 1'b1, 16'h8000, 16'h0000}, 1'b1,
      '{3'd3, 16'h8000, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd3, CMD_ARP, 8'h00, 1'b1, 16'h8008, 16'h0000}, 1'b1,
      '{3'd3, 16'h8003, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd3, CMD_ARP, 8'h00, 1'b1, 16'h8001, 16'h0000}, 1'b1,
      '{3'd3, 16'h8000, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_APPLY, 8'd4, CMD_VIBRATO, 8'hFF, 1'b1, 16'h0000, 16'h0000}, 1'b1,
      '{3'd4, 16'h0000, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd4, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'hFFFF}, 1'b1,
      '{3'd4, 16'h0000, 16'h003A, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_APPLY, 8'd5, CMD_VOL_SLIDE, 8'hF0, 1'b1, 16'h0000, 16'h0000}, 1'b1,
      '{3'd5, 16'h0000, 16'h0000, 7'd0, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd5, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b1,
      '{3'd5, 16'h0000, 16'h0000, 7'd15, 2'd0, 1'b1}},
    '{'{REQ_TICK, 8'd5, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK, 8'd5, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK, 8'd5, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK, 8'd5, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b1,
      '{3'd5, 16'h0000, 16'h0000, 7'd64, 2'd0, 1'b1}},
    '{'{REQ_APPLY, 8'd5, CMD_VOL_SLIDE, 8'h0F, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK, 8'd5, CMD_ARP, 8'h00, 1'b1, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{REQ_APPLY, 8'd6, CMD_VIBRATO, 8'h00, 1'b1, 16'h0123, 16'h4567}, 1'b1,
      '{3'd6, 16'h0123, 16'h4567, 7'd0, 2'd0, 1'b0}},
    '{'{REQ_APPLY, 8'd0, CMD_PORTA_UP, 8'h00, 1'b1, 16'hFFFB, 16'h0000}, 1'b0, '0},
    '{'{REQ_TICK, 8'd0, CMD_ARP, 8'h00, 1'b1, 16'hFFFB, 16'h1111}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic calm;

  cme_req_if req_bus ();
  cme_rsp_if rsp_bus ();

  channel_modulation_effects dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  bit [3:0]         arp_hi_q    [VOICES];
  bit [3:0]         arp_lo_q    [VOICES];
  bit [1:0]         arp_pos_q   [VOICES];
  bit               fx_on_q     [VOICES];
  bit signed [15:0] porta_goal_q[VOICES];
  bit [7:0]         porta_rate_q[VOICES];
  bit [3:0]         vib_rate_q  [VOICES];
  bit [3:0]         vib_amp_q   [VOICES];
  bit [5:0]         vib_pos_q   [VOICES];
  bit signed [4:0]  vol_delta_q [VOICES];
  bit [6:0]         vol_q       [VOICES];
  bit [15:0]        track_pitch [VOICES];
  bit [15:0]        track_phase [VOICES];

  fx_res_t expected_fx_q[$];
  fx_res_t seen_fx;
  fx_res_t want_fx;
  int      error_count;

  function automatic fx_res_t predict_effect(input fx_req_t r);
    fx_res_t    res;
    int         ch;
    int         p;
    int         goal;
    int         v;
    logic [3:0] hi;
    logic [3:0] lo;
    logic [5:0] pos;
    logic [15:0] ph;
    ch = (r.channel >= VOICES) ? VOICES - 1 : int'(r.channel);
    hi = r.param[7:4];
    lo = r.param[3:0];
    p = int'(r.pitch);
    ph = r.phase;
    if (r.kind == REQ_APPLY) begin
      case (r.command)
        CMD_ARP: begin
          arp_hi_q[ch] = hi;
          arp_lo_q[ch] = lo;
          arp_pos_q[ch] = 2'd0;
          fx_on_q[ch] = (r.param != 8'h00);
        end
        CMD_PORTA_UP, CMD_PORTA_DN: begin
          goal = (r.command == CMD_PORTA_UP) ? p + 12 : p - 12;
          if (goal > 32767) goal = 32767;
          if (goal < -32768) goal = -32768;
          porta_goal_q[ch] = goal[15:0];
          porta_rate_q[ch] = r.param;
          fx_on_q[ch] = 1'b1;
        end
        CMD_VIBRATO: begin
          vib_rate_q[ch] = hi;
          vib_amp_q[ch] = lo;
          fx_on_q[ch] = (r.param != 8'h00);
        end
        CMD_VOL_SLIDE: begin
          v = (hi != 4'd0) ? int'(hi) : -int'(lo);
          vol_delta_q[ch] = v[4:0];
          fx_on_q[ch] = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (fx_on_q[ch] && r.voice_on) begin
      if (vib_amp_q[ch] != 4'd0) begin
        pos = vib_pos_q[ch] + 6'(vib_rate_q[ch]);
        vib_pos_q[ch] = pos;
        v = (int'(SINE_LUT[pos[3:0]]) * int'(vib_amp_q[ch])) >> 6;
        ph = ph + v[15:0];
      end
      if (porta_rate_q[ch] != 8'd0) begin
        goal = int'(porta_goal_q[ch]);
        if (p < goal) begin
          p = p + int'(porta_rate_q[ch]);
          if (p > goal) p = goal;
        end else if (p > goal) begin
          p = p - int'(porta_rate_q[ch]);
          if (p < goal) p = goal;
        end
      end
      if (vol_delta_q[ch] != 5'sd0) begin
        v = int'(vol_q[ch]) + int'(vol_delta_q[ch]);
        if (v < 0) v = 0;
        if (v > 64) v = 64;
        vol_q[ch] = v[6:0];
      end
      if (arp_hi_q[ch] != 4'd0 || arp_lo_q[ch] != 4'd0) begin
        arp_pos_q[ch] = (arp_pos_q[ch] == 2'd2) ? 2'd0 : arp_pos_q[ch] + 2'd1;
      end
    end
    res.chan = ch[2:0];
    res.pitch = p[15:0];
    res.phase = ph;
    res.vol = vol_q[ch];
    res.arp = arp_pos_q[ch];
    res.fx = fx_on_q[ch];
    track_pitch[ch] = res.pitch;
    track_phase[ch] = res.phase;
    return res;
  endfunction

  task automatic send_request(input fx_req_t it, input logic fixed, input fx_res_t fixed_res);
    fx_res_t model_res;
    while (!calm && $urandom_range(99) < 11) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid = 1'b1;
    req_bus.req_type = it.kind;
    req_bus.channel = it.channel;
    req_bus.command = it.command;
    req_bus.parameter_req = it.param;
    req_bus.voice_on = it.voice_on;
    req_bus.voice_pitch = it.pitch;
    req_bus.voice_lfo_phase = it.phase;
    do @(posedge clk_i); while (!req_bus.ready);
    model_res = predict_effect(it);
    expected_fx_q.push_back(fixed ? fixed_res : model_res);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 400000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready = calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      seen_fx = '{rsp_bus.out_channel, rsp_bus.new_pitch, rsp_bus.new_lfo_phase,
                  rsp_bus.volume_level, rsp_bus.arp_step, rsp_bus.effect_on};
      if (expected_fx_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: ch=%0d pitch=%0d phase=%0d vol=%0d arp=%0d fx=%0d",
                   seen_fx.chan, seen_fx.pitch, seen_fx.phase, seen_fx.vol, seen_fx.arp,
                   seen_fx.fx);
        end
      end else begin
        want_fx = expected_fx_q.pop_front();
        if (seen_fx.chan !== want_fx.chan || seen_fx.pitch !== want_fx.pitch ||
            seen_fx.phase !== want_fx.phase || seen_fx.vol !== want_fx.vol ||
            seen_fx.arp !== want_fx.arp || seen_fx.fx !== want_fx.fx) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected ch=%0d pitch=%0d phase=%0d vol=%0d arp=%0d fx=%0d",
                     want_fx.chan, want_fx.pitch, want_fx.phase, want_fx.vol, want_fx.arp,
                     want_fx.fx);
            $display("          actual   ch=%0d pitch=%0d phase=%0d vol=%0d arp=%0d fx=%0d",
                     seen_fx.chan, seen_fx.pitch, seen_fx.phase, seen_fx.vol, seen_fx.arp,
                     seen_fx.fx);
          end
        end
      end
    end
  end

  initial begin
    fx_req_t it;
    int      n;
    int      pick;
    int      ch_idx;
    error_count = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_APPLY;
    req_bus.channel = 8'd0;
    req_bus.command = CMD_ARP;
    req_bus.parameter_req = 8'h00;
    req_bus.voice_on = 1'b0;
    req_bus.voice_pitch = 16'h0000;
    req_bus.voice_lfo_phase = 16'h0000;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (n = 0; n < PLAN_ROWS; n++) begin
      send_request(PLAN[n].rq, PLAN[n].fixed, PLAN[n].rs);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // drive both sides without random stalls through a long stretch
      calm = (n >= 300 && n < 480);
      it.kind = ($urandom_range(99) < 40) ? REQ_APPLY : REQ_TICK;
      if ($urandom_range(9) == 0) begin
        it.channel = 8'($urandom_range(255, VOICES));
      end else begin
        it.channel = 8'($urandom_range(VOICES - 1));
      end
      ch_idx = (it.channel >= VOICES) ? VOICES - 1 : int'(it.channel);
      if ($urandom_range(99) < 85) begin
        it.command = KNOWN_CMDS[$urandom_range(4)];
      end else begin
        it.command = 4'($urandom_range(15));
      end
      it.param = ($urandom_range(99) < 12) ? 8'h00 : 8'($urandom);
      it.voice_on = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 70) begin
        it.pitch = track_pitch[ch_idx];
      end else if (pick < 85) begin
        it.pitch = 16'($urandom);
      end else if ($urandom_range(1) == 1) begin
        it.pitch = 16'h7FFF - 16'($urandom_range(15));
      end else begin
        it.pitch = 16'h8000 + 16'($urandom_range(15));
      end
      it.phase = ($urandom_range(99) < 70) ? track_phase[ch_idx] : 16'($urandom);
      send_request(it, 1'b0, '0);
    end
    calm = 1'b0;
    req_bus.valid = 1'b0;

    while (expected_fx_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/cme_pkg.sv
src/cme_req_if.sv
src/cme_rsp_if.sv
src/cme_fx_store.sv
src/cme_fx_alu.sv
src/channel_modulation_effects.sv
tb/tb_top.sv
